@@ hdl/fvl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT volume layout package
// Shared constants, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package fvl_pkg;

   localparam int BLOCK_SHIFT_DEFAULT = 9;

   // Status codes carried in the status word.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_PROTECTED = 2'd1;
   localparam logic [1:0] ST_TOO_SMALL = 2'd2;
   localparam logic [1:0] ST_TOO_LARGE = 2'd3;

   // Layout word numbers.
   localparam logic [4:0] WORD_STATUS     = 5'd0;
   localparam logic [4:0] WORD_FAT_TYPE   = 5'd1;
   localparam logic [4:0] WORD_SHIFT      = 5'd2;
   localparam logic [4:0] WORD_CLUSTERS   = 5'd3;
   localparam logic [4:0] WORD_FAT_BLOCKS = 5'd4;
   localparam logic [4:0] WORD_BOOT       = 5'd5;
   localparam logic [4:0] WORD_FAT1       = 5'd6;
   localparam logic [4:0] WORD_FAT2       = 5'd7;
   localparam logic [4:0] WORD_ROOT       = 5'd8;
   localparam logic [4:0] WORD_ROOT_BLKS  = 5'd9;
   localparam logic [4:0] WORD_DATA_START = 5'd10;
   localparam logic [4:0] WORD_TOTAL      = 5'd11;
   localparam logic [4:0] WORD_PART_TYPE  = 5'd12;
   localparam logic [4:0] WORD_HEADS      = 5'd13;
   localparam logic [4:0] WORD_SPT        = 5'd14;
   localparam logic [4:0] WORD_START_CHS  = 5'd15;
   localparam logic [4:0] WORD_END_CHS    = 5'd16;
   localparam logic [4:0] WORD_USER_START = 5'd17;
   localparam logic [4:0] WORD_USER_COUNT = 5'd18;

   // Size limits.
   localparam logic [31:0] FAT32_MIN_BLOCKS  = 32'd4209984;
   localparam logic [31:0] FAT16_MAX_CLUS    = 32'd65524;
   localparam logic [31:0] FAT12_MAX_CLUS    = 32'd4085;
   localparam logic [31:0] F32_CAP_SMALL     = 32'd33513472;
   localparam logic [31:0] F32_CAP_MID       = 32'd67067904;
   localparam logic [31:0] F32_CAP_LARGE     = 32'd268402688;
   localparam logic [31:0] CHS_LIMIT_BLOCKS  = 32'd16450560;
   localparam logic [31:0] MAX_MEDIA_BLOCKS  = 32'd268435456;
   localparam logic [31:0] SMALL_FAT_LIMIT   = 32'd131072;
   localparam logic [31:0] FAT12_PART_LIMIT  = 32'd32680;

   // Partition type codes.
   localparam logic [3:0] PART_FAT12     = 4'h1;
   localparam logic [3:0] PART_FAT16_SM  = 4'h4;
   localparam logic [3:0] PART_FAT16     = 4'h6;
   localparam logic [3:0] PART_FAT32_CHS = 4'hB;
   localparam logic [3:0] PART_FAT32_LBA = 4'hC;

   typedef enum logic [4:0] {
      CMD_NONE     = 5'd0,
      CMD_LOAD     = 5'd1,
      CMD_CHECK    = 5'd2,
      CMD_GEOM     = 5'd3,
      CMD_INIT     = 5'd4,
      CMD_FATSZ    = 5'd5,
      CMD_CLUS     = 5'd6,
      CMD_RECOUNT  = 5'd7,
      CMD_F32      = 5'd8,
      CMD_F32_CNT  = 5'd9,
      CMD_F32_FAT  = 5'd10,
      CMD_ROOT     = 5'd11,
      CMD_FAT2     = 5'd12,
      CMD_FAT1     = 5'd13,
      CMD_BOOT     = 5'd14,
      CMD_TOTAL    = 5'd15,
      CMD_SYSID    = 5'd16,
      CMD_DIV_CYL  = 5'd17,
      CMD_DIV_HEAD = 5'd18,
      CMD_PACK     = 5'd19,
      CMD_EMIT     = 5'd20
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       chs_end;
      logic [4:0] word_id;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic [1:0] code;
      logic       fat32;
      logic       converged;
      logic       div_done;
      logic       out_free;
   } status_type;

endpackage

@@ hdl/fvl_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT volume layout radix-2 divider
// Restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module fvl_divider
   import fvl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [15:0] remainder
);

   logic [31:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] shifted;
   logic [17:0] diff;

   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = 16'd0;
         dvs_in   = divisor;
         count_in = 6'd32;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[30:0], ~diff[17]};
         rem_in   = diff[17] ? shifted[15:0] : diff[15:0];
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      count_ff <= count_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ hdl/fvl_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT volume layout datapath
// Layout registers, arithmetic for each command step and the result register.
// ----------------------------------------------------------------------------
module fvl_datapath
   import fvl_pkg::*;
#(
   parameter int BLOCK_SHIFT = BLOCK_SHIFT_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic [31:0] req_media_blocks,
   input  logic        req_is_serial_flash,
   input  logic        req_write_locked,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [4:0]  rsp_word_id,
   output logic [31:0] rsp_word_value,
   output logic        rsp_last_word
);

   localparam logic [31:0] BSIZE_M1 = 32'((64'd1 << BLOCK_SHIFT) - 64'd1);

   logic        small_fat_ff, small_fat_in;
   logic [31:0] blk_ff, blk_in;
   logic        flash_ff, flash_in;
   logic        locked_ff, locked_in;
   logic        fat12_ok_ff, fat12_ok_in;
   logic [1:0]  code_ff, code_in;
   logic        fat32_ff, fat32_in;
   logic        fat12_sel_ff, fat12_sel_in;
   logic [7:0]  hpc_ff, hpc_in;
   logic [5:0]  spt_ff, spt_in;
   logic [13:0] per_cyl_ff, per_cyl_in;
   logic [2:0]  shift_ff, shift_in;
   logic [15:0] unit_ff, unit_in;
   logic [31:0] mask_ff, mask_in;
   logic [7:0]  root_blks_ff, root_blks_in;
   logic [31:0] clscnt_ff, clscnt_in;
   logic [31:0] est_ff, est_in;
   logic [31:0] fat_blks_ff, fat_blks_in;
   logic [31:0] clus_ff, clus_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] fat2_ff, fat2_in;
   logic [31:0] fat1_ff, fat1_in;
   logic [31:0] boot_ff, boot_in;
   logic [31:0] tot_ff, tot_in;
   logic [31:0] ubase_ff, ubase_in;
   logic [31:0] ucount_ff, ucount_in;
   logic [3:0]  sys_id_ff, sys_id_in;
   logic        end_far_ff, end_far_in;
   logic        converged_ff, converged_in;
   logic [31:0] cyl_ff, cyl_in;
   logic [23:0] start_chs_ff, start_chs_in;
   logic [23:0] end_chs_ff, end_chs_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  rsp_id_ff, rsp_id_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [7:0]  geom_hpc;
   logic [5:0]  geom_spt;
   logic [2:0]  geom_shift;
   logic [15:0] geom_unit;
   logic [31:0] cnt_base;
   logic [31:0] init_cnt;
   logic [31:0] recount;
   logic [31:0] recount_min;
   logic [31:0] c2;
   logic [31:0] fat12_bytes;
   logic [31:0] fat_bytes;
   logic [31:0] fat_blks_calc;
   logic [31:0] unit_m1;
   logic [31:0] two_fat;
   logic [31:0] clus_calc;
   logic        div_start;
   logic [31:0] div_dividend;
   logic [15:0] div_divisor;
   logic        div_done;
   logic [31:0] div_quo;
   logic [15:0] div_rem;
   logic [23:0] packed_chs;
   logic [31:0] word_value;

   fvl_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Geometry and cluster size for the FAT12/FAT16 branch.
   always_comb begin
      geom_spt = 6'd32;
      if (blk_ff <= 32'd32768) begin
         geom_hpc = 8'd2;
         geom_spt = 6'd16;
      end else if (blk_ff <= 32'd65536)   geom_hpc = 8'd2;
      else if (blk_ff <= 32'd131072)      geom_hpc = 8'd4;
      else if (blk_ff <= 32'd262144)      geom_hpc = 8'd8;
      else if (blk_ff <= 32'd524288)      geom_hpc = 8'd16;
      else if (blk_ff <= 32'd1048576)     geom_hpc = 8'd32;
      else if (blk_ff <= 32'd2097152)     geom_hpc = 8'd64;
      else                                geom_hpc = 8'd128;

      if (flash_ff) begin
         geom_unit = 16'd8;
         if (blk_ff <= 32'd4096)       geom_shift = 3'd0;
         else if (blk_ff <= 32'd8192)  geom_shift = 3'd1;
         else if (blk_ff <= 32'd16384) geom_shift = 3'd2;
         else                          geom_shift = 3'd3;
      end else if (fat12_ok_ff && blk_ff <= 32'd16384) begin
         geom_shift = 3'd4;
         geom_unit  = 16'd16;
      end else if (fat12_ok_ff && blk_ff <= SMALL_FAT_LIMIT) begin
         geom_shift = 3'd5;
         geom_unit  = 16'd32;
      end else if (blk_ff <= 32'd524288) begin
         geom_shift = 3'd5;
         geom_unit  = 16'd64;
      end else if (blk_ff <= 32'd2097152) begin
         geom_shift = 3'd5;
         geom_unit  = 16'd128;
      end else begin
         geom_shift = 3'd6;
         geom_unit  = 16'd128;
      end
   end

   assign unit_m1       = {16'd0, unit_ff} - 32'd1;
   assign cnt_base      = flash_ff ? {16'd0, unit_ff} : {15'd0, unit_ff, 1'b0};
   assign init_cnt      = ((blk_ff - cnt_base) & mask_ff) >> shift_ff;
   assign recount       = ((blk_ff - clus_ff) & mask_ff) >> shift_ff;
   assign recount_min   = (recount > est_ff) ? est_ff : recount;
   assign c2            = clscnt_ff + 32'd2;
   assign fat12_bytes   = (c2 + {c2[30:0], 1'b0} + 32'd1) >> 1;
   assign fat_bytes     = fat32_ff ? {c2[29:0], 2'b00} :
                          (fat12_sel_ff ? fat12_bytes : {c2[30:0], 1'b0});
   assign fat_blks_calc = (fat_bytes + BSIZE_M1) >> BLOCK_SHIFT;
   assign two_fat       = {fat_blks_ff[30:0], 1'b0};
   assign clus_calc     = flash_ff ?
      ((32'd2 + two_fat + {24'd0, root_blks_ff} + unit_m1) & mask_ff) :
      ({16'd0, unit_ff} + ((32'd1 + two_fat + {24'd0, root_blks_ff} + unit_m1) & mask_ff));

   assign div_start    = (cmd.op == CMD_DIV_CYL) || (cmd.op == CMD_DIV_HEAD);
   assign div_dividend = (cmd.op == CMD_DIV_HEAD) ? {16'd0, div_rem} :
                         (cmd.chs_end ? (blk_ff - 32'd1) : boot_ff);
   assign div_divisor  = (cmd.op == CMD_DIV_HEAD) ? {10'd0, spt_ff} : {2'b00, per_cyl_ff};

   // Packed CHS: head in the low byte, sector with cylinder bits 9:8 above it,
   // then cylinder bits 7:0. A cylinder beyond 1023 saturates.
   always_comb begin
      if (cyl_ff > 32'd1023) packed_chs = {8'hFF, 2'b11, 6'd63, 8'd254};
      else packed_chs = {cyl_ff[7:0], cyl_ff[9:8], 6'(div_rem[5:0] + 6'd1), div_quo[7:0]};
   end

   always_comb begin
      case (cmd.word_id)
         WORD_STATUS:     word_value = {30'd0, code_ff};
         WORD_FAT_TYPE:   word_value = fat32_ff ? 32'd32 : (fat12_sel_ff ? 32'd12 : 32'd16);
         WORD_SHIFT:      word_value = {29'd0, shift_ff};
         WORD_CLUSTERS:   word_value = clscnt_ff;
         WORD_FAT_BLOCKS: word_value = fat_blks_ff;
         WORD_BOOT:       word_value = boot_ff;
         WORD_FAT1:       word_value = fat1_ff;
         WORD_FAT2:       word_value = fat2_ff;
         WORD_ROOT:       word_value = root_ff;
         WORD_ROOT_BLKS:  word_value = {24'd0, root_blks_ff};
         WORD_DATA_START: word_value = clus_ff;
         WORD_TOTAL:      word_value = tot_ff;
         WORD_PART_TYPE:  word_value = {28'd0, sys_id_ff};
         WORD_HEADS:      word_value = {24'd0, hpc_ff};
         WORD_SPT:        word_value = {26'd0, spt_ff};
         WORD_START_CHS:  word_value = {8'd0, start_chs_ff};
         WORD_END_CHS:    word_value = {8'd0, end_chs_ff};
         WORD_USER_START: word_value = ubase_ff;
         WORD_USER_COUNT: word_value = ucount_ff;
         default:         word_value = 32'd0;
      endcase
   end

   always_comb begin
      small_fat_in = csr_wr_en ? csr_wr_data : small_fat_ff;
      blk_in = blk_ff;             flash_in = flash_ff;         locked_in = locked_ff;
      fat12_ok_in = fat12_ok_ff;   code_in = code_ff;           fat32_in = fat32_ff;
      fat12_sel_in = fat12_sel_ff; hpc_in = hpc_ff;             spt_in = spt_ff;
      per_cyl_in = per_cyl_ff;     shift_in = shift_ff;         unit_in = unit_ff;
      mask_in = mask_ff;           root_blks_in = root_blks_ff; clscnt_in = clscnt_ff;
      est_in = est_ff;             fat_blks_in = fat_blks_ff;   clus_in = clus_ff;
      root_in = root_ff;           fat2_in = fat2_ff;           fat1_in = fat1_ff;
      boot_in = boot_ff;           tot_in = tot_ff;             ubase_in = ubase_ff;
      ucount_in = ucount_ff;       sys_id_in = sys_id_ff;       end_far_in = end_far_ff;
      converged_in = converged_ff; cyl_in = cyl_ff;
      start_chs_in = start_chs_ff; end_chs_in = end_chs_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_id_in = rsp_id_ff;       rsp_value_in = rsp_value_ff; rsp_last_in = rsp_last_ff;

      case (cmd.op)
         CMD_LOAD: begin
            blk_in      = req_media_blocks;
            flash_in    = req_is_serial_flash;
            locked_in   = req_write_locked;
            fat12_ok_in = small_fat_ff;
         end
         CMD_CHECK: begin
            if (locked_ff)                                   code_in = ST_PROTECTED;
            else if (!fat12_ok_ff && blk_ff <= SMALL_FAT_LIMIT) code_in = ST_TOO_SMALL;
            else if (blk_ff > MAX_MEDIA_BLOCKS)              code_in = ST_TOO_LARGE;
            else                                             code_in = ST_OK;
            fat32_in = !(flash_ff || blk_ff < FAT32_MIN_BLOCKS);
         end
         CMD_GEOM: begin
            hpc_in       = geom_hpc;
            spt_in       = geom_spt;
            shift_in     = geom_shift;
            unit_in      = geom_unit;
            mask_in      = ~({16'd0, geom_unit} - 32'd1);
            root_blks_in = 8'd32;
         end
         CMD_INIT: begin
            per_cyl_in   = 14'({6'd0, hpc_ff} * {8'd0, spt_ff});
            fat12_sel_in = fat12_ok_ff && (init_cnt < FAT12_MAX_CLUS);
            if (!(fat12_ok_ff && (init_cnt < FAT12_MAX_CLUS)) && init_cnt > FAT16_MAX_CLUS)
               clscnt_in = FAT16_MAX_CLUS;
            else
               clscnt_in = init_cnt;
         end
         CMD_FATSZ: begin
            est_in      = clscnt_ff;
            fat_blks_in = fat_blks_calc;
         end
         CMD_CLUS: clus_in = clus_calc;
         CMD_RECOUNT: begin
            clscnt_in    = recount_min;
            converged_in = (recount_min == est_ff);
         end
         CMD_F32: begin
            hpc_in       = (blk_ff <= 32'd8388608) ? 8'd128 : 8'd255;
            spt_in       = 6'd63;
            fat12_sel_in = 1'b0;
            if (blk_ff <= 32'd67108864) begin
               shift_in     = 3'd6;
               unit_in      = 16'd8192;
               mask_in      = 32'hFFFF_E000;
               root_blks_in = 8'd64;
               if (blk_ff <= 32'd33554432) begin
                  if (blk_ff > F32_CAP_SMALL) blk_in = F32_CAP_SMALL;
                  clus_in = 32'd16384;
               end else begin
                  if (blk_ff > F32_CAP_MID) blk_in = F32_CAP_MID;
                  clus_in = 32'd24576;
               end
            end else begin
               shift_in     = 3'd7;
               unit_in      = 16'd32768;
               mask_in      = 32'hFFFF_8000;
               root_blks_in = 8'd128;
               if (blk_ff > F32_CAP_LARGE) blk_in = F32_CAP_LARGE;
               clus_in = 32'd65536;
            end
         end
         CMD_F32_CNT: begin
            clscnt_in  = recount;
            per_cyl_in = 14'({6'd0, hpc_ff} * {8'd0, spt_ff});
         end
         CMD_F32_FAT: fat_blks_in = fat_blks_calc;
         CMD_ROOT: begin
            root_in = fat32_ff ? clus_ff : clus_ff - 32'd32;
            blk_in  = clus_ff + (clscnt_ff << shift_ff);
         end
         CMD_FAT2: fat2_in = root_ff - fat_blks_ff;
         CMD_FAT1: fat1_in = fat2_ff - fat_blks_ff;
         CMD_BOOT: begin
            if (fat32_ff)      boot_in = {16'd0, unit_ff};
            else if (flash_ff) boot_in = 32'd1;
            else               boot_in = fat1_ff - 32'd1;
         end
         CMD_TOTAL: begin
            tot_in    = blk_ff - boot_ff;
            ubase_in  = root_ff + {24'd0, root_blks_ff};
            ucount_in = fat32_ff ? ((clscnt_ff - 32'd1) << shift_ff) : (clscnt_ff << shift_ff);
         end
         CMD_SYSID: begin
            end_far_in = blk_ff > CHS_LIMIT_BLOCKS;
            if (fat32_ff)
               sys_id_in = (blk_ff <= CHS_LIMIT_BLOCKS) ? PART_FAT32_CHS : PART_FAT32_LBA;
            else if (tot_ff < FAT12_PART_LIMIT) sys_id_in = PART_FAT12;
            else if (tot_ff < 32'd65536)        sys_id_in = PART_FAT16_SM;
            else                                sys_id_in = PART_FAT16;
         end
         CMD_DIV_HEAD: cyl_in = div_quo;
         CMD_PACK: begin
            if (!cmd.chs_end)   start_chs_in = packed_chs;
            else if (end_far_ff) end_chs_in  = {8'hFF, 8'hFF, 8'd254};
            else                end_chs_in   = packed_chs;
         end
         CMD_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_id_in    = cmd.word_id;
            rsp_value_in = word_value;
            rsp_last_in  = cmd.last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         small_fat_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         small_fat_ff <= small_fat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;             flash_ff <= flash_in;         locked_ff <= locked_in;
      fat12_ok_ff <= fat12_ok_in;   code_ff <= code_in;           fat32_ff <= fat32_in;
      fat12_sel_ff <= fat12_sel_in; hpc_ff <= hpc_in;             spt_ff <= spt_in;
      per_cyl_ff <= per_cyl_in;     shift_ff <= shift_in;         unit_ff <= unit_in;
      mask_ff <= mask_in;           root_blks_ff <= root_blks_in; clscnt_ff <= clscnt_in;
      est_ff <= est_in;             fat_blks_ff <= fat_blks_in;   clus_ff <= clus_in;
      root_ff <= root_in;           fat2_ff <= fat2_in;           fat1_ff <= fat1_in;
      boot_ff <= boot_in;           tot_ff <= tot_in;             ubase_ff <= ubase_in;
      ucount_ff <= ucount_in;       sys_id_ff <= sys_id_in;       end_far_ff <= end_far_in;
      converged_ff <= converged_in; cyl_ff <= cyl_in;
      start_chs_ff <= start_chs_in; end_chs_ff <= end_chs_in;
      rsp_id_ff <= rsp_id_in;       rsp_value_ff <= rsp_value_in; rsp_last_ff <= rsp_last_in;
   end

   assign status.code      = code_ff;
   assign status.fat32     = fat32_ff;
   assign status.converged = converged_ff;
   assign status.div_done  = div_done;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_word_id    = rsp_id_ff;
   assign rsp_word_value = rsp_value_ff;
   assign rsp_last_word  = rsp_last_ff;

endmodule

@@ hdl/fvl_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT volume layout controller
// Sequences the datapath steps for one request and the emission of its words.
// ----------------------------------------------------------------------------
module fvl_controller
   import fvl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [23:0] {
      S_IDLE      = 24'b1 << 0,
      S_CHECK     = 24'b1 << 1,
      S_DECIDE    = 24'b1 << 2,
      S_GEOM      = 24'b1 << 3,
      S_INIT      = 24'b1 << 4,
      S_FATSZ     = 24'b1 << 5,
      S_CLUS      = 24'b1 << 6,
      S_RECOUNT   = 24'b1 << 7,
      S_LOOPCHK   = 24'b1 << 8,
      S_F32       = 24'b1 << 9,
      S_F32_CNT   = 24'b1 << 10,
      S_F32_FAT   = 24'b1 << 11,
      S_ROOT      = 24'b1 << 12,
      S_FAT2      = 24'b1 << 13,
      S_FAT1      = 24'b1 << 14,
      S_BOOT      = 24'b1 << 15,
      S_TOTAL     = 24'b1 << 16,
      S_SYSID     = 24'b1 << 17,
      S_DIV_CYL   = 24'b1 << 18,
      S_WAIT_CYL  = 24'b1 << 19,
      S_DIV_HEAD  = 24'b1 << 20,
      S_WAIT_HEAD = 24'b1 << 21,
      S_PACK      = 24'b1 << 22,
      S_EMIT      = 24'b1 << 23
   } state_type;

   state_type  state_ff, state_in;
   logic       error_ff, error_in;
   logic       chs_end_ff, chs_end_in;
   logic [4:0] word_ff, word_in;
   logic       emit_last;

   assign emit_last = error_ff || (word_ff == WORD_USER_COUNT);

   always_comb begin
      state_in    = state_ff;
      error_in    = error_ff;
      chs_end_in  = chs_end_ff;
      word_in     = word_ff;
      cmd.op      = CMD_NONE;
      cmd.chs_end = chs_end_ff;
      cmd.word_id = word_ff;
      cmd.last    = emit_last;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = CMD_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.op   = CMD_CHECK;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            word_in    = WORD_STATUS;
            chs_end_in = 1'b0;
            error_in   = (status.code != ST_OK);
            if (status.code != ST_OK) state_in = S_EMIT;
            else if (status.fat32)    state_in = S_F32;
            else                      state_in = S_GEOM;
         end
         S_GEOM:    begin cmd.op = CMD_GEOM;    state_in = S_INIT;    end
         S_INIT:    begin cmd.op = CMD_INIT;    state_in = S_FATSZ;   end
         S_FATSZ:   begin cmd.op = CMD_FATSZ;   state_in = S_CLUS;    end
         S_CLUS:    begin cmd.op = CMD_CLUS;    state_in = S_RECOUNT; end
         S_RECOUNT: begin cmd.op = CMD_RECOUNT; state_in = S_LOOPCHK; end
         S_LOOPCHK: state_in = status.converged ? S_ROOT : S_FATSZ;
         S_F32:     begin cmd.op = CMD_F32;     state_in = S_F32_CNT; end
         S_F32_CNT: begin cmd.op = CMD_F32_CNT; state_in = S_F32_FAT; end
         S_F32_FAT: begin cmd.op = CMD_F32_FAT; state_in = S_ROOT;    end
         S_ROOT:    begin cmd.op = CMD_ROOT;    state_in = S_FAT2;    end
         S_FAT2:    begin cmd.op = CMD_FAT2;    state_in = S_FAT1;    end
         S_FAT1:    begin cmd.op = CMD_FAT1;    state_in = S_BOOT;    end
         S_BOOT:    begin cmd.op = CMD_BOOT;    state_in = S_TOTAL;   end
         S_TOTAL:   begin cmd.op = CMD_TOTAL;   state_in = S_SYSID;   end
         S_SYSID:   begin cmd.op = CMD_SYSID;   state_in = S_DIV_CYL; end
         S_DIV_CYL: begin cmd.op = CMD_DIV_CYL; state_in = S_WAIT_CYL; end
         S_WAIT_CYL: begin
            if (status.div_done) state_in = S_DIV_HEAD;
         end
         S_DIV_HEAD: begin cmd.op = CMD_DIV_HEAD; state_in = S_WAIT_HEAD; end
         S_WAIT_HEAD: begin
            if (status.div_done) state_in = S_PACK;
         end
         S_PACK: begin
            cmd.op = CMD_PACK;
            if (chs_end_ff) begin
               state_in = S_EMIT;
            end else begin
               chs_end_in = 1'b1;
               state_in   = S_DIV_CYL;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.op = CMD_EMIT;
               if (emit_last) state_in = S_IDLE;
               else           word_in  = word_ff + 5'd1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         error_ff   <= 1'b0;
         chs_end_ff <= 1'b0;
         word_ff    <= WORD_STATUS;
      end else begin
         state_ff   <= state_in;
         error_ff   <= error_in;
         chs_end_ff <= chs_end_in;
         word_ff    <= word_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

@@ hdl/fat_volume_layout_calculator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT volume layout calculator
// Computes the FAT12/FAT16/FAT32 layout of a medium and streams it as words.
// ----------------------------------------------------------------------------
// Each request carries a medium size in blocks and two flags, serial flash and
// write protect. The block answers with a status word alone, marked last, when
// the medium is protected, too small or too large. Otherwise it answers with
// nineteen numbered words (status, FAT type, cluster shift, cluster count,
// FAT size, boot, FAT1, FAT2, root, root size, data start, total sectors,
// partition type, heads, sectors per track, packed start and end CHS, user
// area start and size), the last one marked. One request is worked on at a
// time; a new request is taken as soon as the previous one has handed its last
// word to the output register. For a good layout the FAT12/FAT16 path repeats
// its fixed-point loop until the cluster count converges, while FAT32 skips
// it. The four CHS divisions run through one shared bit-serial divider, and
// the 19 words leave at one per cycle when the sink is ready. The small-FAT
// enable register resets to one and may be written only while no request is
// in progress.
// ----------------------------------------------------------------------------
module fat_volume_layout_calculator
   import fvl_pkg::*;
#(
   parameter int BLOCK_SHIFT = BLOCK_SHIFT_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   // Configuration: bit 0 is small_fat_enable.
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] media_blocks
   input  logic [1:0]  req_tuser,   // [0] is_serial_flash, [1] write_locked
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [4:0] word_id, [36:5] word_value, [39:37] zero
   output logic        rsp_tlast    // last_word
);

   cmd_type     cmd;
   status_type  status;
   logic [4:0]  rsp_word_id;
   logic [31:0] rsp_word_value;

   // The controller only steps the datapath; all layout values live there.
   fvl_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fvl_datapath #(
      .BLOCK_SHIFT (BLOCK_SHIFT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_media_blocks    (req_tdata),
      .req_is_serial_flash (req_tuser[0]),
      .req_write_locked    (req_tuser[1]),
      .cmd                 (cmd),
      .status              (status),
      .rsp_tready          (rsp_tready),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_word_id         (rsp_word_id),
      .rsp_word_value      (rsp_word_value),
      .rsp_last_word       (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, rsp_word_value, rsp_word_id};

`ifndef SYNTH
   // A request is worked on alone: no second request right after acceptance.
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another was in progress");

   // A nonzero status word always ends its run.
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[4:0] == WORD_STATUS && rsp_tdata[36:5] != 32'd0)
      |-> rsp_tlast)
      else $error("error status not marked last");

   // A run ends only on an error status or on the last layout word.
   a_last_word_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
      ((rsp_tdata[4:0] == WORD_STATUS && rsp_tdata[36:5] != 32'd0) ||
       rsp_tdata[4:0] == WORD_USER_COUNT))
      else $error("last mark on an unexpected word");
`endif

endmodule
